// ----- hdl/olist_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the ordered list core.
// Used by olist_ctrl, olist_dp and ordered_list_insert_delete_locate_core.
package olist_pkg;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;

    // command opcodes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic                load_in;     // capture a new command
        logic                cnt_clr;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                ptr_first;   // pointer to entry 0
        logic                ptr_last;    // pointer to entry count-1
        logic                ptr_pos;     // pointer to entry position-1
        logic                ptr_inc;
        logic                ptr_dec;
        logic                wr_shift_up; // mem[ptr+1] <= read data
        logic                wr_shift_dn; // mem[ptr-1] <= read data
        logic                wr_value;    // mem[position-1] <= item value
        logic                rm_load;     // capture removed value
        logic                found_load;  // capture match position
        logic                st_load;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;    // move result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             cnt_zero;
        logic             cnt_full;
        logic             ins_bad;
        logic             ins_at_end;
        logic             del_bad;
        logic             ptr_at_pos;
        logic             ptr_at_last;
        logic             match;
    } t_dp_stat;

endpackage

// ----- hdl/olist_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the ordered list core: entry memory, count, walk pointer,
// result and output registers. Depends on olist_pkg; driven by olist_ctrl.
module olist_dp #(
    parameter int CAPACITY = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  olist_pkg::t_dp_cmd                i_cmd_bus,
    output olist_pkg::t_dp_stat               o_stat,
    input  logic [olist_pkg::CMD_W-1:0]       i_cmd,
    input  logic [olist_pkg::POS_W-1:0]       i_position,
    input  logic [olist_pkg::VAL_W-1:0]       i_item_value,
    output logic [olist_pkg::STATUS_W-1:0]    o_status,
    output logic [olist_pkg::VAL_W-1:0]       o_removed_value,
    output logic [olist_pkg::POS_W-1:0]       o_found_position,
    output logic [olist_pkg::POS_W-1:0]       o_entry_count
);
    import olist_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // latched command
    logic [CMD_W-1:0]    r_op;
    logic [POS_W-1:0]    r_pos;
    logic [VAL_W-1:0]    r_val;

    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [VAL_W-1:0]    r_rdata;
    logic [VAL_W-1:0]    mem [CAPACITY];

    logic [STATUS_W-1:0] r_res_status;
    logic [VAL_W-1:0]    r_res_removed;
    logic [POS_W-1:0]    r_res_found;

    logic [STATUS_W-1:0] r_out_status;
    logic [VAL_W-1:0]    r_out_removed;
    logic [POS_W-1:0]    r_out_found;
    logic [POS_W-1:0]    r_out_count;

    logic [CMPW-1:0]     w_pos_x, w_cnt_x, w_pos_m1, w_cnt_m1, w_found_x;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [VAL_W-1:0]    w_wr_data;

    // widened operands for position checks
    assign w_pos_x   = CMPW'(r_pos);
    assign w_cnt_x   = CMPW'(r_count);
    assign w_pos_m1  = w_pos_x - CMPW'(1);
    assign w_cnt_m1  = w_cnt_x - CMPW'(1);
    assign w_found_x = CMPW'(r_ptr) + CMPW'(1);

    // status toward the controller
    always_comb begin
        o_stat.op          = r_op;
        o_stat.cnt_zero    = (r_count == '0);
        o_stat.cnt_full    = (w_cnt_x >= CMPW'(CAPACITY));
        o_stat.ins_bad     = (w_pos_x == '0) || (w_pos_x > w_cnt_x + CMPW'(1));
        o_stat.ins_at_end  = (w_pos_x == w_cnt_x + CMPW'(1));
        o_stat.del_bad     = (w_pos_x == '0) || (w_pos_x > w_cnt_x);
        o_stat.ptr_at_pos  = (r_ptr == w_pos_m1[AW-1:0]);
        o_stat.ptr_at_last = (r_ptr == w_cnt_m1[AW-1:0]);
        o_stat.match       = (r_rdata == r_val);
    end

    // walk pointer; the memory is always read at the next pointer
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd_bus.ptr_first) begin
            n_ptr = '0;
        end else if (i_cmd_bus.ptr_last) begin
            n_ptr = w_cnt_m1[AW-1:0];
        end else if (i_cmd_bus.ptr_pos) begin
            n_ptr = w_pos_m1[AW-1:0];
        end else if (i_cmd_bus.ptr_inc) begin
            n_ptr = r_ptr + AW'(1);
        end else if (i_cmd_bus.ptr_dec) begin
            n_ptr = r_ptr - AW'(1);
        end
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd_bus.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd_bus.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd_bus.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    // memory write port
    always_comb begin
        w_wr_en   = i_cmd_bus.wr_shift_up | i_cmd_bus.wr_shift_dn | i_cmd_bus.wr_value;
        w_wr_addr = w_pos_m1[AW-1:0];
        w_wr_data = r_val;
        if (i_cmd_bus.wr_shift_up) begin
            w_wr_addr = r_ptr + AW'(1);
            w_wr_data = r_rdata;
        end else if (i_cmd_bus.wr_shift_dn) begin
            w_wr_addr = r_ptr - AW'(1);
            w_wr_data = r_rdata;
        end
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= mem[n_ptr];
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    // command capture and working result
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_in) begin
            r_op          <= i_cmd;
            r_pos         <= i_position;
            r_val         <= i_item_value;
            r_res_status  <= STS_OK;
            r_res_removed <= '0;
            r_res_found   <= '0;
        end else begin
            if (i_cmd_bus.st_load) begin
                r_res_status <= i_cmd_bus.st_code;
            end
            if (i_cmd_bus.rm_load) begin
                r_res_removed <= r_rdata;
            end
            if (i_cmd_bus.found_load) begin
                r_res_found <= w_found_x[POS_W-1:0];
            end
        end
    end

    // output register, held until the result transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.out_load) begin
            r_out_status  <= r_res_status;
            r_out_removed <= r_res_removed;
            r_out_found   <= r_res_found;
            r_out_count   <= w_cnt_x[POS_W-1:0];
        end
    end

    assign o_status         = r_out_status;
    assign o_removed_value  = r_out_removed;
    assign o_found_position = r_out_found;
    assign o_entry_count    = r_out_count;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMPW'(r_count) <= CMPW'(CAPACITY)))
        else $error("entry count above capacity");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_bus.cnt_inc && !i_cmd_bus.cnt_clr) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count by one");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ({1'b0, w_wr_addr} < (AW+1)'(CAPACITY)))
        else $error("memory write outside capacity");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.wr_shift_up |-> (CMPW'(r_ptr) < w_cnt_x))
        else $error("shift up reads beyond the list");

endmodule

// ----- hdl/olist_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the ordered list core: sequences one command at a time
// and owns both handshakes. Depends on olist_pkg; drives olist_dp.
module olist_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  olist_pkg::t_dp_stat  i_stat,
    output olist_pkg::t_dp_cmd   o_cmd_bus
);
    import olist_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_INS_SHIFT = 3'd2;
    localparam logic [2:0] S_INS_WR    = 3'd3;
    localparam logic [2:0] S_DEL_RD    = 3'd4;
    localparam logic [2:0] S_DEL_SHIFT = 3'd5;
    localparam logic [2:0] S_LOC       = 3'd6;
    localparam logic [2:0] S_FIN       = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // next state and datapath commands
    always_comb begin
        n_state   = r_state;
        o_cmd_bus = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd_bus.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                case (i_stat.op)
                    CMD_CLEAR: begin
                        o_cmd_bus.cnt_clr = 1'b1;
                    end
                    CMD_INSERT: begin
                        if (i_stat.cnt_full) begin
                            o_cmd_bus.st_load = 1'b1;
                            o_cmd_bus.st_code = STS_FULL;
                        end else if (i_stat.ins_bad) begin
                            o_cmd_bus.st_load = 1'b1;
                            o_cmd_bus.st_code = STS_BADPOS;
                        end else if (i_stat.ins_at_end) begin
                            n_state = S_INS_WR;
                        end else begin
                            o_cmd_bus.ptr_last = 1'b1;
                            n_state = S_INS_SHIFT;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd_bus.st_load = 1'b1;
                            o_cmd_bus.st_code = STS_EMPTY;
                        end else if (i_stat.del_bad) begin
                            o_cmd_bus.st_load = 1'b1;
                            o_cmd_bus.st_code = STS_BADPOS;
                        end else begin
                            o_cmd_bus.ptr_pos = 1'b1;
                            n_state = S_DEL_RD;
                        end
                    end
                    CMD_LOCATE: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd_bus.st_load = 1'b1;
                            o_cmd_bus.st_code = STS_NOTFOUND;
                        end else begin
                            o_cmd_bus.ptr_first = 1'b1;
                            n_state = S_LOC;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            // move entries up one place, from the tail down to the position
            S_INS_SHIFT: begin
                o_cmd_bus.wr_shift_up = 1'b1;
                if (i_stat.ptr_at_pos) begin
                    n_state = S_INS_WR;
                end else begin
                    o_cmd_bus.ptr_dec = 1'b1;
                end
            end
            S_INS_WR: begin
                o_cmd_bus.wr_value = 1'b1;
                o_cmd_bus.cnt_inc  = 1'b1;
                n_state = S_FIN;
            end
            S_DEL_RD: begin
                o_cmd_bus.rm_load = 1'b1;
                if (i_stat.ptr_at_last) begin
                    o_cmd_bus.cnt_dec = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd_bus.ptr_inc = 1'b1;
                    n_state = S_DEL_SHIFT;
                end
            end
            // move entries down one place, up to the tail
            S_DEL_SHIFT: begin
                o_cmd_bus.wr_shift_dn = 1'b1;
                if (i_stat.ptr_at_last) begin
                    o_cmd_bus.cnt_dec = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd_bus.ptr_inc = 1'b1;
                end
            end
            // linear search from the head
            S_LOC: begin
                if (i_stat.match) begin
                    o_cmd_bus.found_load = 1'b1;
                    n_state = S_FIN;
                end else if (i_stat.ptr_at_last) begin
                    o_cmd_bus.st_load = 1'b1;
                    o_cmd_bus.st_code = STS_NOTFOUND;
                    n_state = S_FIN;
                end else begin
                    o_cmd_bus.ptr_inc = 1'b1;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd_bus.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd_bus.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECODE))
        else $error("accepted command not decoded");

    a_count_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd_bus.cnt_clr, o_cmd_bus.cnt_inc, o_cmd_bus.cnt_dec}))
        else $error("conflicting count updates");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !o_cmd_bus.out_load)
        else $error("pending result overwritten");

endmodule

// ----- hdl/ordered_list_insert_delete_locate_core.sv -----
`timescale 1ns / 1ps
// Ordered list core: one command per transfer, one result per command.
// One command at a time: the next transfer is taken the cycle after the result is registered.
// Reset clears the count and the handshake state; entries stay undefined.
module ordered_list_insert_delete_locate_core #(
    parameter int CAPACITY = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [olist_pkg::CMD_W-1:0]            i_cmd,
    input  logic [olist_pkg::POS_W-1:0]            i_position,
    input  logic signed [olist_pkg::VAL_W-1:0]     i_item_value,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [olist_pkg::STATUS_W-1:0]         o_status,
    output logic signed [olist_pkg::VAL_W-1:0]     o_removed_value,
    output logic [olist_pkg::POS_W-1:0]            o_found_position,
    output logic [olist_pkg::POS_W-1:0]            o_entry_count
);
    import olist_pkg::*;

    t_dp_cmd          w_cmd_bus;
    t_dp_stat         w_stat;
    logic [VAL_W-1:0] w_removed;

    olist_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_stat    (w_stat),
        .o_cmd_bus (w_cmd_bus)
    );

    olist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_bus        (w_cmd_bus),
        .o_stat           (w_stat),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_item_value     ($unsigned(i_item_value)),
        .o_status         (o_status),
        .o_removed_value  (w_removed),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    assign o_removed_value = $signed(w_removed);

endmodule

// ----- verif/tb_ordered_list_insert_delete_locate_core.sv -----
`timescale 1ns / 1ps
// Testbench for ordered_list_insert_delete_locate_core: a shadow list predicts
// every result, and directed plus random command streams run under idle and stall.
// Depends on olist_pkg and the core RTL only.
module tb_ordered_list_insert_delete_locate_core;
    import olist_pkg::*;

    localparam int LIST_CAP    = 32;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] removed;
        logic [POS_W-1:0]        found;
        logic [POS_W-1:0]        count;
    } t_list_outcome;

    // Shadow copy of the list: predicts each outcome and checks the core's results
    class t_shadow_list;
        logic signed [VAL_W-1:0] slots [LIST_CAP];
        int                      len;
        t_list_outcome           awaited_results [$];
        int                      mismatches;
        int                      commands;
        int                      results_seen;
        int                      peak_len;
        int                      cmd_seen [4];
        int                      status_seen [5];

        function new();
            len = 0;
            mismatches = 0;
            commands = 0;
            results_seen = 0;
            peak_len = 0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int length();
            return len;
        endfunction

        function logic signed [VAL_W-1:0] entry_at(int idx);
            return slots[idx];
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        // Apply one accepted command to the shadow list and queue its outcome
        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            t_list_outcome r;
            int            p;
            int            k;
            r.status  = STS_OK;
            r.removed = '0;
            r.found   = '0;
            p = int'(pos);
            case (cmd)
                CMD_CLEAR: len = 0;
                CMD_INSERT: begin
                    if (len >= LIST_CAP) begin
                        r.status = STS_FULL;
                    end else if (p < 1 || p > len + 1) begin
                        r.status = STS_BADPOS;
                    end else begin
                        for (k = len; k >= p; k--)
                            slots[k] = slots[k-1];
                        slots[p-1] = val;
                        len++;
                    end
                end
                CMD_DELETE: begin
                    if (len == 0) begin
                        r.status = STS_EMPTY;
                    end else if (p < 1 || p > len) begin
                        r.status = STS_BADPOS;
                    end else begin
                        r.removed = slots[p-1];
                        for (k = p; k < len; k++)
                            slots[k-1] = slots[k];
                        len--;
                    end
                end
                default: begin
                    // first match wins; only live entries are searched
                    r.status = STS_NOTFOUND;
                    for (k = 0; k < len; k++) begin
                        if (slots[k] == val) begin
                            r.found  = POS_W'(k + 1);
                            r.status = STS_OK;
                            break;
                        end
                    end
                end
            endcase
            r.count = POS_W'(len);
            if (len > peak_len) peak_len = len;
            cmd_seen[cmd]++;
            status_seen[r.status]++;
            commands++;
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
                flag($sformatf("%s: expected %0d, got %0d", name, exp_v, act_v));
        endfunction

        // Compare one result transfer against the oldest outcome
        function void check_result(logic [STATUS_W-1:0] status,
                                   logic signed [VAL_W-1:0] removed,
                                   logic [POS_W-1:0] found, logic [POS_W-1:0] count);
            t_list_outcome e;
            results_seen++;
            if (awaited_results.size() == 0) begin
                flag($sformatf("result with no command pending (status %0d)", status));
                return;
            end
            e = awaited_results.pop_front();
            compare_field("status", e.status, status);
            compare_field("removed_value", e.removed, removed);
            compare_field("found_position", e.found, found);
            compare_field("entry_count", e.count, count);
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [CMD_W-1:0]        i_cmd;
    logic [POS_W-1:0]        i_position;
    logic signed [VAL_W-1:0] i_item_value;
    logic                    o_valid;
    logic                    i_stall;
    logic [STATUS_W-1:0]     o_status;
    logic signed [VAL_W-1:0] o_removed_value;
    logic [POS_W-1:0]        o_found_position;
    logic [POS_W-1:0]        o_entry_count;

    t_shadow_list sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    ordered_list_insert_delete_locate_core #(.CAPACITY(LIST_CAP)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_found_position(o_found_position),
        .o_entry_count   (o_entry_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // result monitor: a transfer is valid high with stall low at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_removed_value, o_found_position, o_entry_count);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("ordered_list_insert_delete_locate_core verification failed");
            $finish;
        end
    end

    // Drive one command, with a random gap first, and wait for its transfer
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] val);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (o_stall);
        sb.note_command(cmd, pos, val);
    endtask

    // Hold off the sender until every outstanding result has arrived
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3, 4:    return VAL_W'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    // mostly a value that is in the list, so locate hits at varied depths
    function automatic logic signed [VAL_W-1:0] locate_value();
        if (sb.length() > 0 && $urandom_range(9) < 6)
            return sb.entry_at($urandom_range(sb.length() - 1));
        return pick_value();
    endfunction

    function automatic logic [POS_W-1:0] bad_position(int limit);
        if ($urandom_range(1) == 0) return '0;
        return POS_W'($urandom_range(63, limit + 1));
    endfunction

    function automatic logic [POS_W-1:0] any_position();
        return POS_W'($urandom_range(63));
    endfunction

    task automatic fill_list();
        while (sb.length() < LIST_CAP)
            send_command(CMD_INSERT, POS_W'($urandom_range(sb.length() + 1, 1)),
                         pick_value());
        // inserts bounced by a full list
        repeat ($urandom_range(2, 1))
            send_command(CMD_INSERT, any_position(), pick_value());
    endtask

    task automatic drain_list();
        while (sb.length() > 0)
            send_command(CMD_DELETE, POS_W'($urandom_range(sb.length(), 1)), $urandom);
        send_command(CMD_DELETE, any_position(), $urandom);
    endtask

    task automatic mixed_run(int n);
        int roll;
        int len;
        repeat (n) begin
            roll = $urandom_range(99);
            len  = sb.length();
            if (roll < 40) begin
                if ($urandom_range(99) < 85)
                    send_command(CMD_INSERT, POS_W'($urandom_range(len + 1, 1)),
                                 pick_value());
                else
                    send_command(CMD_INSERT, bad_position(len + 1), pick_value());
            end else if (roll < 65) begin
                if (len > 0)
                    send_command(CMD_DELETE, POS_W'($urandom_range(len, 1)), $urandom);
                else
                    send_command(CMD_DELETE, any_position(), $urandom);
            end else if (roll < 93) begin
                send_command(CMD_LOCATE, any_position(), locate_value());
            end else if (roll < 97) begin
                send_command($urandom_range(1) ? CMD_INSERT : CMD_DELETE,
                             bad_position(len + 1), pick_value());
            end else begin
                send_command(CMD_CLEAR, any_position(), $urandom);
            end
        end
    endtask

    task automatic random_phase(int quota);
        int goal;
        int pick;
        goal = sb.commands + quota;
        while (sb.commands < goal) begin
            pick = $urandom_range(99);
            if (pick < 18)      fill_list();
            else if (pick < 36) drain_list();
            else if (pick < 40) send_command(CMD_CLEAR, any_position(), $urandom);
            else                mixed_run($urandom_range(30, 10));
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_cmd        = CMD_CLEAR;
        i_position   = '0;
        i_item_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list errors, bad positions, ends and middle, duplicates
        send_command(CMD_LOCATE, 6'd0, 32'sd0);
        send_command(CMD_DELETE, 6'd1, 32'sd5);
        send_command(CMD_INSERT, 6'd0, 32'sd9);
        send_command(CMD_INSERT, 6'd2, 32'sd9);
        send_command(CMD_INSERT, 6'd1, 32'sh7fff_ffff);
        send_command(CMD_INSERT, 6'd1, 32'sh8000_0000);
        send_command(CMD_INSERT, 6'd3, -32'sd1);
        send_command(CMD_INSERT, 6'd2, 32'sd0);
        send_command(CMD_INSERT, 6'd63, 32'sd1);
        send_command(CMD_LOCATE, 6'd63, 32'sh8000_0000);
        send_command(CMD_LOCATE, 6'd0, -32'sd1);
        send_command(CMD_INSERT, 6'd5, 32'sd0);
        send_command(CMD_LOCATE, 6'd17, 32'sd0);
        send_command(CMD_LOCATE, 6'd0, 32'sd12345);
        send_command(CMD_DELETE, 6'd0, 32'sd0);
        send_command(CMD_DELETE, 6'd63, -32'sd1);
        send_command(CMD_DELETE, 6'd6, 32'sd0);
        send_command(CMD_DELETE, 6'd5, 32'sd0);
        send_command(CMD_DELETE, 6'd1, 32'sd0);
        send_command(CMD_DELETE, 6'd2, 32'sd0);
        send_command(CMD_CLEAR, 6'd63, -32'sd1);
        send_command(CMD_LOCATE, 6'd1, 32'sd0);
        send_command(CMD_INSERT, 6'd1, 32'sd42);
        send_command(CMD_CLEAR, 6'd0, 32'sd0);

        // sender hold-off until the core has answered everything
        wait_for_results();

        // random phases: free running, sender idle, receiver stall, both
        random_phase(200);
        idle_pct = 56;
        random_phase(200);
        wait_for_results();
        idle_pct  = 0;
        stall_pct = 56;
        random_phase(200);
        idle_pct  = 24;
        stall_pct = 24;
        random_phase(200);

        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.outstanding()));

        $display("%0d commands (clear %0d, insert %0d, delete %0d, locate %0d), %0d results,",
                 sb.commands, sb.cmd_seen[CMD_CLEAR], sb.cmd_seen[CMD_INSERT],
                 sb.cmd_seen[CMD_DELETE], sb.cmd_seen[CMD_LOCATE], sb.results_seen);
        $display("ok %0d, full %0d, bad position %0d, empty %0d, not found %0d; peak length %0d",
                 sb.status_seen[STS_OK], sb.status_seen[STS_FULL],
                 sb.status_seen[STS_BADPOS], sb.status_seen[STS_EMPTY],
                 sb.status_seen[STS_NOTFOUND], sb.peak_len);
        if (sb.mismatches == 0) begin
            $display("ordered_list_insert_delete_locate_core verification clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("ordered_list_insert_delete_locate_core verification failed");
        end
        $finish;
    end

endmodule
